>>> rtl/shs_pkg.sv
// Shared constants for the SHA-256 stream hasher: round constants and initial hash values.
`timescale 1ns / 1ps

package shs_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned HASH_WORDS  = 8;

    // Padding marker byte and the fill position where the length field starts.
    localparam logic [7:0] PAD_MARKER   = 8'h80;
    localparam logic [2:0] LEN_FIELD_HI = 3'b111;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

>>> rtl/sha256_stream_hasher_unit.sv
// SHA-256 over a byte stream with one shared round unit and a small sequencer.
`timescale 1ns / 1ps

// A beat carrying a byte, or an empty beat, is taken whenever the sequencer is idle. The beat
// that completes a 64-byte block is followed by the rounds and the hash update, with ready low.
// An end-of-message beat is followed by the padding bytes, one per cycle, up to the block end,
// one compression per padded block (one or two), the load of the digest register once it is
// free, and the digest beat. The single round unit performs one round per cycle.
// Reset (aresetn low, synchronous) restores the initial hash values and clears all counts.
module sha256_stream_hasher_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] byte_present
    input  logic         s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // [63:0] digest_word0, [127:64] digest_word1,
                                    // [191:128] digest_word2, [255:192] digest_word3
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;   // taking message beats
    localparam logic [2:0] ST_PAD  = 3'd1;   // shifting in padding bytes, one per cycle
    localparam logic [2:0] ST_COMP = 3'd2;   // 64 rounds, one per cycle
    localparam logic [2:0] ST_FIN  = 3'd3;   // add working variables into the hash
    localparam logic [2:0] ST_EMIT = 3'd4;   // load the digest register once it is free

    logic [2:0]   state_reg;
    logic [5:0]   fill_reg;       // bytes held in the current block
    logic [5:0]   rnd_reg;        // round index during compression
    logic [63:0]  count_reg;      // message length in bits, wraps modulo 2^64
    logic         eom_pend_reg;   // end mark arrived with the byte that filled a block
    logic         pad_reg;        // the block being built or compressed is padding
    logic         marker_reg;     // the 0x80 marker byte has been placed
    logic         len_ok_reg;     // the current block ends with the length field
    logic         out_valid_reg;
    logic [255:0] out_data_reg;

    // The block is a 512-bit shift line. Bytes enter at the low end, so after 64 bytes
    // byte 0 sits at the top and word j is bits [511-32j -: 32]. During compression the
    // same line is the 16-word message schedule window: word 0 is W[t].
    logic [511:0] blk_reg;

    shs_pkg::word_t hash_reg [shs_pkg::HASH_WORDS];
    shs_pkg::word_t work_reg [shs_pkg::HASH_WORDS];

    function automatic shs_pkg::word_t rotr(input shs_pkg::word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Round unit and schedule expansion.
    shs_pkg::word_t w0, w1, w9, w14, new_w;
    shs_pkg::word_t sig_e, sig_a, ch, maj, t1, t2;
    shs_pkg::word_t ea, ee;

    always_comb begin
        w0    = blk_reg[511 -: 32];
        w1    = blk_reg[479 -: 32];
        w9    = blk_reg[223 -: 32];
        w14   = blk_reg[63 -: 32];
        new_w = w0 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w9
              + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));
        ea    = work_reg[0];
        ee    = work_reg[4];
        sig_e = rotr(ee, 6) ^ rotr(ee, 11) ^ rotr(ee, 25);
        ch    = (ee & work_reg[5]) ^ (~ee & work_reg[6]);
        t1    = work_reg[7] + sig_e + ch + shs_pkg::ROUND_K[rnd_reg] + w0;
        sig_a = rotr(ea, 2) ^ rotr(ea, 13) ^ rotr(ea, 22);
        maj   = (ea & work_reg[1]) ^ (ea & work_reg[2]) ^ (work_reg[1] & work_reg[2]);
        t2    = sig_a + maj;
    end

    // Padding byte: the marker first, then zeros, with the big-endian bit count in the
    // last eight positions of the final block.
    logic [7:0] pad_byte;

    always_comb begin
        priority if (!marker_reg) begin
            pad_byte = shs_pkg::PAD_MARKER;
        end else if (len_ok_reg && (fill_reg[5:3] == shs_pkg::LEN_FIELD_HI)) begin
            pad_byte = count_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    logic in_beat;
    logic out_beat;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Payload: block line, working variables and digest register.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && s_tuser) begin
                    blk_reg <= {blk_reg[503:0], s_tdata};
                end
                for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
                    work_reg[i] <= hash_reg[i];
                end
            end
            ST_PAD: begin
                blk_reg <= {blk_reg[503:0], pad_byte};
                for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
                    work_reg[i] <= hash_reg[i];
                end
            end
            ST_COMP: begin
                blk_reg     <= {blk_reg[479:0], new_w};
                work_reg[7] <= work_reg[6];
                work_reg[6] <= work_reg[5];
                work_reg[5] <= work_reg[4];
                work_reg[4] <= work_reg[3] + t1;
                work_reg[3] <= work_reg[2];
                work_reg[2] <= work_reg[1];
                work_reg[1] <= work_reg[0];
                work_reg[0] <= t1 + t2;
            end
            ST_FIN: begin
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    for (int i = 0; i < 4; i++) begin
                        out_data_reg[64*i +: 64] <= {hash_reg[2*i], hash_reg[2*i+1]};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state and hash words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            count_reg     <= '0;
            eom_pend_reg  <= 1'b0;
            pad_reg       <= 1'b0;
            marker_reg    <= 1'b0;
            len_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
                hash_reg[i] <= shs_pkg::INIT_HASH[i];
            end
        end else begin
            // In ST_EMIT a departing digest beat is replaced by the new one below.
            if (out_beat && (state_reg != ST_EMIT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        if (s_tuser) begin
                            fill_reg  <= fill_reg + 6'd1;
                            count_reg <= count_reg + 64'd8;
                        end
                        priority if (s_tuser && (fill_reg == 6'd63)) begin
                            // The block is full: compress first, pad afterward if marked.
                            eom_pend_reg <= s_tlast;
                            rnd_reg      <= '0;
                            state_reg    <= ST_COMP;
                        end else if (s_tlast) begin
                            pad_reg    <= 1'b1;
                            marker_reg <= 1'b0;
                            len_ok_reg <= 1'b0;
                            state_reg  <= ST_PAD;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_PAD: begin
                    fill_reg <= fill_reg + 6'd1;
                    if (!marker_reg) begin
                        marker_reg <= 1'b1;
                        // A marker placed before the length field leaves room for it here.
                        if (fill_reg[5:3] != shs_pkg::LEN_FIELD_HI) begin
                            len_ok_reg <= 1'b1;
                        end
                    end
                    if (fill_reg == 6'd63) begin
                        rnd_reg   <= '0;
                        state_reg <= ST_COMP;
                    end
                end
                ST_COMP: begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
                        hash_reg[i] <= hash_reg[i] + work_reg[i];
                    end
                    priority if (pad_reg && len_ok_reg) begin
                        state_reg <= ST_EMIT;
                    end else if (pad_reg) begin
                        // The marker filled the block; the next one carries only the length.
                        len_ok_reg <= 1'b1;
                        state_reg  <= ST_PAD;
                    end else if (eom_pend_reg) begin
                        eom_pend_reg <= 1'b0;
                        pad_reg      <= 1'b1;
                        marker_reg   <= 1'b0;
                        len_ok_reg   <= 1'b0;
                        state_reg    <= ST_PAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        count_reg     <= '0;
                        fill_reg      <= '0;
                        pad_reg       <= 1'b0;
                        marker_reg    <= 1'b0;
                        len_ok_reg    <= 1'b0;
                        for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
                            hash_reg[i] <= shs_pkg::INIT_HASH[i];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> tb/sha256_digest_checker.sv
// Watches both channels of the hasher, predicts each digest and compares the result beats.
`timescale 1ns / 1ps

module sha256_digest_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] byte_present
    input  logic         s_tlast,   // end_of_message
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [255:0] m_tdata,   // [63:0] digest_word0 .. [255:192] digest_word3
    output int unsigned  mismatch_count,
    output int unsigned  digests_pending
);

    shs_pkg::word_t hash_state [shs_pkg::HASH_WORDS];
    logic [7:0]     block_bytes [shs_pkg::BLOCK_BYTES];
    logic [5:0]     fill_level;
    logic [63:0]    bit_total;
    logic [255:0]   expected_digests [$];

    function automatic shs_pkg::word_t rotr32(shs_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        shs_pkg::word_t sched [shs_pkg::ROUNDS];
        shs_pkg::word_t wv [shs_pkg::HASH_WORDS];
        shs_pkg::word_t s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) begin
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < shs_pkg::ROUNDS; i++) begin
            s0 = rotr32(sched[i-15], 7) ^ rotr32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr32(sched[i-2], 17) ^ rotr32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        for (int i = 0; i < shs_pkg::HASH_WORDS; i++) wv[i] = hash_state[i];
        for (int i = 0; i < shs_pkg::ROUNDS; i++) begin
            t1 = wv[7] + (rotr32(wv[4], 6) ^ rotr32(wv[4], 11) ^ rotr32(wv[4], 25))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + shs_pkg::ROUND_K[i] + sched[i];
            t2 = (rotr32(wv[0], 2) ^ rotr32(wv[0], 13) ^ rotr32(wv[0], 22))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
        end
        for (int i = 0; i < shs_pkg::HASH_WORDS; i++) hash_state[i] += wv[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < shs_pkg::HASH_WORDS; i++) hash_state[i] = shs_pkg::INIT_HASH[i];
        fill_level = '0;
        bit_total  = '0;
    endfunction

    // Absorbs one accepted input beat; an end mark pads, finishes and queues the digest.
    function automatic void absorb_beat(logic [7:0] data_byte, logic present, logic last);
        logic [255:0] digest;
        if (present) begin
            block_bytes[fill_level] = data_byte;
            bit_total += 64'd8;
            if (fill_level == 6'd63) compress_block();
            fill_level = fill_level + 6'd1;
        end
        if (last) begin
            block_bytes[fill_level] = shs_pkg::PAD_MARKER;
            for (int i = int'(fill_level) + 1; i < shs_pkg::BLOCK_BYTES; i++) begin
                block_bytes[i] = '0;
            end
            // No room left for the length field: the padding spills into a second block.
            if (fill_level[5:3] == shs_pkg::LEN_FIELD_HI) begin
                compress_block();
                for (int i = 0; i < shs_pkg::BLOCK_BYTES; i++) block_bytes[i] = '0;
            end
            for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_total[63 - 8*i -: 8];
            compress_block();
            for (int k = 0; k < 4; k++) begin
                digest[64*k +: 64] = {hash_state[2*k], hash_state[2*k+1]};
            end
            expected_digests.push_back(digest);
            restart_message();
        end
    endfunction

    always @(posedge aclk) begin
        logic [255:0] want;
        if (!aresetn) begin
            restart_message();
            expected_digests.delete();
            mismatch_count = 0;
        end else begin
            if (s_tvalid && s_tready) absorb_beat(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_digests.size() == 0) begin
                    $error("digest beat %h arrived with no digest expected", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_digests.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (m_tdata[64*k +: 64] !== want[64*k +: 64]) begin
                            $error("digest_word%0d mismatch: expected %h, actual %h",
                                   k, want[64*k +: 64], m_tdata[64*k +: 64]);
                            mismatch_count++;
                        end
                    end
                end
            end
        end
        digests_pending = expected_digests.size();
    end

endmodule

>>> tb/sha256_stream_hasher_unit_tb.sv
// Stimulus, clock, reset, watchdog and verdict for the SHA-256 stream hasher.
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_tb;

    // Longest legal silence follows one end-of-message beat: the padding bytes, two compressions
    // and a stalled digest beat. This limit leaves a wide margin over that.
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 300;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tuser  = 1'b0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;

    int unsigned mismatch_count;
    int unsigned digests_pending;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stall_cycles   = 0;
    int unsigned items_sent     = 0;
    int unsigned messages_sent  = 0;

    always #1 aclk = ~aclk;

    sha256_stream_hasher_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sha256_digest_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .digests_pending (digests_pending)
    );

    // The receiver drops ready at random, at the rate of the current phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Any accepted beat on either channel restarts the count of silent cycles.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("sha256_stream_hasher_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat was taken.
    task automatic send_beat(logic [7:0] data_byte, logic present, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (last) messages_sent++;
    endtask

    // Holds the input quiet until every digest in flight has been delivered.
    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (digests_pending != 0) @(negedge aclk);
    endtask

    // One message of random bytes with occasional empty beats mixed in. The end mark
    // rides either on the last byte or on a separate beat with no byte.
    task automatic send_message(int unsigned len);
        logic end_on_byte;
        end_on_byte = (len != 0) && $urandom_range(1);
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(99) < 8) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int unsigned pick_length();
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(8);
            // Around the padding limits: 55/56 and 63/64 bytes into a block.
            3, 4, 5, 6: return 64 * $urandom_range(1) + 50 + $urandom_range(16);
            default: return $urandom_range(140);
        endcase
    endfunction

    initial begin
        int unsigned phase_items;
        int unsigned phase_msgs;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 14;
        recv_stall_pct = 45;

        // Directed: the empty message, the classic three-byte message, a lone idle beat,
        // the byte extremes, an end mark without a byte and two one-byte messages.
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);

        // Three random phases: sender idles lightly with a busy receiver, then the
        // reverse, then full throughput on both sides. Each starts from a drained block.
        for (int phase = 0; phase < 3; phase++) begin
            wait_for_digests();
            send_idle_pct  = (phase == 0) ? 14 : (phase == 1) ? 45 : 0;
            recv_stall_pct = (phase == 0) ? 45 : (phase == 1) ? 14 : 0;
            phase_items = items_sent;
            phase_msgs  = messages_sent;
            while (items_sent - phase_items < 300 || messages_sent - phase_msgs < 4) begin
                send_message(pick_length());
            end
        end

        wait_for_digests();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && digests_pending == 0) begin
            $display("sha256_stream_hasher_unit_tb: done, clean");
        end else begin
            $display("sha256_stream_hasher_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> sha256_stream_hasher_unit.f
rtl/shs_pkg.sv
rtl/sha256_stream_hasher_unit.sv
tb/sha256_digest_checker.sv
tb/sha256_stream_hasher_unit_tb.sv
